/* sv/slle_pkg.sv */
// Shared types and codes for the static linked list engine.
// Used by slle_ctrl, slle_dpath and static_linked_list_engine; no dependencies.
package slle_pkg;

   localparam int NODE_COUNT_DEFAULT = 1024;
   localparam int MODE_W = 3;
   localparam int VALUE_W = 32;
   localparam int STATUS_W = 2;

   // command codes carried in the mode field
   localparam logic [MODE_W-1:0] MODE_ADD_FIRST    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_INSERT_AFTER = 3'd1;
   localparam logic [MODE_W-1:0] MODE_ERASE_AFTER  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_ERASE_VALUE  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_FIND         = 3'd4;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD       = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_INS_LINK,
      ST_INS_HOOK,
      ST_EA_SUCC,
      ST_EA_UNLINK,
      ST_WALK,
      ST_CMP,
      ST_RESP
   } state_type;

   // link store write address source
   typedef enum logic [1:0] {
      LWA_FRESH,
      LWA_POS,
      LWA_PREV
   } link_waddr_type;

   // result index source
   typedef enum logic [1:0] {
      RI_ZERO,
      RI_FRESH,
      RI_CUR
   } res_idx_type;

   typedef struct packed {
      logic                cmd_load;   // capture an accepted word
      logic                rd_en;      // read both stores
      logic                rd_cur;     // read address: cur (else position)
      logic                val_wr;     // write value of the fresh node
      logic                link_wr;    // write a link
      link_waddr_type      link_waddr;
      logic                link_wfresh; // link data: fresh index (else read link)
      logic                alloc_bump; // advance allocation counter
      logic                walk_init;  // start a list walk at the head
      logic                cur_take;   // cur <= read link
      logic                walk_step;  // prev <= cur, count one link
      logic                res_load;   // latch result
      res_idx_type         res_idx;
      logic [STATUS_W-1:0] res_status;
      logic                rsp_load;   // move result into the output register
   } dp_cmd_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              pos_bad;
      logic              full;
      logic              link_zero;
      logic              walk_end;
      logic              match;
      logic              rsp_busy;
   } dp_status_type;

endpackage

/* sv/slle_dpath.sv */
// Datapath of the static linked list engine: value and link stores, head link,
// allocation counter, walk registers and output register. Depends on slle_pkg.
module slle_dpath #(
   parameter int NODE_COUNT = slle_pkg::NODE_COUNT_DEFAULT,
   parameter int IDX_W      = $clog2(NODE_COUNT)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  slle_pkg::dp_cmd_type          cmd,
   output slle_pkg::dp_status_type       status,
   input  logic [slle_pkg::MODE_W-1:0]   req_mode,
   input  logic [IDX_W-1:0]              req_position,
   input  logic [slle_pkg::VALUE_W-1:0]  req_value,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [IDX_W-1:0]              rsp_node_index,
   output logic [slle_pkg::STATUS_W-1:0] rsp_status
);
   import slle_pkg::*;

   localparam int STEP_W = $clog2(NODE_COUNT + 1);

   // stores; head link lives in a register so that reset empties the list
   logic [VALUE_W-1:0] value_mem [NODE_COUNT];
   logic [IDX_W-1:0]   link_mem  [NODE_COUNT];

   logic [MODE_W-1:0]   mode_ff;
   logic [IDX_W-1:0]    pos_ff;
   logic [VALUE_W-1:0]  val_ff;
   logic [IDX_W-1:0]    head_ff;
   logic [IDX_W-1:0]    last_ff;
   logic [IDX_W-1:0]    cur_ff;
   logic [IDX_W-1:0]    prev_ff;
   logic [STEP_W-1:0]   steps_ff;
   logic [IDX_W-1:0]    link_q_ff;
   logic                rd_head_ff;
   logic [VALUE_W-1:0]  value_q_ff;
   logic [IDX_W-1:0]    res_idx_ff;
   logic [STATUS_W-1:0] res_st_ff;
   logic                rsp_valid_ff;
   logic [IDX_W-1:0]    rsp_idx_ff;
   logic [STATUS_W-1:0] rsp_st_ff;

   logic [IDX_W-1:0] fresh;
   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] link_rd;
   logic [IDX_W-1:0] wr_addr;
   logic [IDX_W-1:0] wr_data;

   always_comb begin
      fresh   = last_ff + IDX_W'(1);
      rd_addr = cmd.rd_cur ? cur_ff : pos_ff;
      link_rd = rd_head_ff ? head_ff : link_q_ff;
      case (cmd.link_waddr)
         LWA_FRESH: wr_addr = fresh;
         LWA_POS:   wr_addr = pos_ff;
         LWA_PREV:  wr_addr = prev_ff;
         default:   wr_addr = pos_ff;
      endcase
      wr_data = cmd.link_wfresh ? fresh : link_rd;
   end

   // capture the command word; add-first always links behind the head
   always_ff @(posedge clock) begin
      if (cmd.cmd_load) begin
         mode_ff <= req_mode;
         pos_ff  <= (req_mode == MODE_ADD_FIRST) ? '0 : req_position;
         val_ff  <= req_value;
      end
   end

   // store reads, registered
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         link_q_ff  <= link_mem[rd_addr];
         value_q_ff <= value_mem[rd_addr];
         rd_head_ff <= (rd_addr == '0);
      end
   end

   // store writes; link of node zero goes to the head register
   always_ff @(posedge clock) begin
      if (cmd.val_wr) begin
         value_mem[fresh] <= val_ff;
      end
      if (cmd.link_wr && wr_addr != '0) begin
         link_mem[wr_addr] <= wr_data;
      end
   end

   // head link and allocation counter
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         last_ff <= '0;
      end else begin
         if (cmd.link_wr && wr_addr == '0) begin
            head_ff <= wr_data;
         end
         if (cmd.alloc_bump) begin
            last_ff <= fresh;
         end
      end
   end

   // walk registers
   always_ff @(posedge clock) begin
      if (cmd.walk_init) begin
         cur_ff   <= head_ff;
         prev_ff  <= '0;
         steps_ff <= '0;
      end else begin
         if (cmd.cur_take) begin
            cur_ff <= link_rd;
         end
         if (cmd.walk_step) begin
            prev_ff  <= cur_ff;
            steps_ff <= steps_ff + STEP_W'(1);
         end
      end
   end

   // result latch
   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         res_st_ff <= cmd.res_status;
         case (cmd.res_idx)
            RI_FRESH: res_idx_ff <= fresh;
            RI_CUR:   res_idx_ff <= cur_ff;
            default:  res_idx_ff <= '0;
         endcase
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_idx_ff <= res_idx_ff;
         rsp_st_ff  <= res_st_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_node_index = rsp_idx_ff;
   assign rsp_status     = rsp_st_ff;

   always_comb begin
      status.mode      = mode_ff;
      status.pos_bad   = (pos_ff > last_ff);
      status.full      = (last_ff == IDX_W'(NODE_COUNT - 1));
      status.link_zero = (link_rd == '0);
      status.walk_end  = (cur_ff == '0) || (steps_ff == STEP_W'(NODE_COUNT));
      status.match     = (value_q_ff == val_ff);
      status.rsp_busy  = rsp_valid_ff && !rsp_ready;
   end

endmodule

/* sv/slle_ctrl.sv */
// Controller of the static linked list engine: sequences one command word
// through the datapath. Depends on slle_pkg.
module slle_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  slle_pkg::dp_status_type status,
   output slle_pkg::dp_cmd_type    cmd
);
   import slle_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.link_waddr = LWA_POS;
      cmd.res_idx    = RI_ZERO;
      cmd.res_status = STATUS_OK;
      req_ready      = (state_ff == ST_IDLE) && !reset;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !reset) begin
               cmd.cmd_load = 1'b1;
               state_in     = ST_CHECK;
            end
         end
         // decode: screen mode, position and space, start the first read or walk
         ST_CHECK: begin
            case (status.mode)
               MODE_ADD_FIRST, MODE_INSERT_AFTER: begin
                  if (status.mode == MODE_INSERT_AFTER && status.pos_bad) begin
                     cmd.res_load   = 1'b1;
                     cmd.res_status = STATUS_BAD;
                     state_in       = ST_RESP;
                  end else if (status.full) begin
                     cmd.res_load   = 1'b1;
                     cmd.res_status = STATUS_FULL;
                     state_in       = ST_RESP;
                  end else begin
                     cmd.rd_en = 1'b1;
                     state_in  = ST_INS_LINK;
                  end
               end
               MODE_ERASE_AFTER: begin
                  if (status.pos_bad) begin
                     cmd.res_load   = 1'b1;
                     cmd.res_status = STATUS_BAD;
                     state_in       = ST_RESP;
                  end else begin
                     cmd.rd_en = 1'b1;
                     state_in  = ST_EA_SUCC;
                  end
               end
               MODE_ERASE_VALUE, MODE_FIND: begin
                  cmd.walk_init = 1'b1;
                  state_in      = ST_WALK;
               end
               default: begin
                  cmd.res_load   = 1'b1;
                  cmd.res_status = STATUS_BAD;
                  state_in       = ST_RESP;
               end
            endcase
         end
         // fresh node takes the value and the old successor of position
         ST_INS_LINK: begin
            cmd.val_wr     = 1'b1;
            cmd.link_wr    = 1'b1;
            cmd.link_waddr = LWA_FRESH;
            state_in       = ST_INS_HOOK;
         end
         // hook fresh node after position and commit the allocation
         ST_INS_HOOK: begin
            cmd.link_wr     = 1'b1;
            cmd.link_waddr  = LWA_POS;
            cmd.link_wfresh = 1'b1;
            cmd.alloc_bump  = 1'b1;
            cmd.res_load    = 1'b1;
            cmd.res_idx     = RI_FRESH;
            cmd.res_status  = STATUS_OK;
            state_in        = ST_RESP;
         end
         ST_EA_SUCC: begin
            if (status.link_zero) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = STATUS_BAD;
               state_in       = ST_RESP;
            end else begin
               cmd.cur_take = 1'b1;
               state_in     = ST_EA_UNLINK;
            end
         end
         // read successor's link first, then bypass the successor
         ST_EA_UNLINK: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_cur = 1'b1;
            state_in   = ST_CMP;
         end
         ST_WALK: begin
            if (status.walk_end) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = STATUS_NOT_FOUND;
               state_in       = ST_RESP;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_cur = 1'b1;
               state_in   = ST_CMP;
            end
         end
         // erase_after lands here too: its unlink needs no value compare
         ST_CMP: begin
            if (status.mode == MODE_ERASE_AFTER) begin
               cmd.link_wr    = 1'b1;
               cmd.link_waddr = LWA_POS;
               cmd.res_load   = 1'b1;
               cmd.res_idx    = RI_CUR;
               state_in       = ST_RESP;
            end else if (status.match) begin
               if (status.mode == MODE_ERASE_VALUE) begin
                  cmd.link_wr    = 1'b1;
                  cmd.link_waddr = LWA_PREV;
               end
               cmd.res_load = 1'b1;
               cmd.res_idx  = RI_CUR;
               state_in     = ST_RESP;
            end else begin
               cmd.cur_take  = 1'b1;
               cmd.walk_step = 1'b1;
               state_in      = ST_WALK;
            end
         end
         // hand the result to the output register once it is free
         ST_RESP: begin
            if (!status.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* sv/static_linked_list_engine.sv */
// Static linked list engine: one command word in, one result word out.
// A rejected word goes straight to its result; add-first/insert_after write the fresh
// node, then hook it after position; erase_after reads the successor, then its link,
// then bypasses it; find/erase_value walk from the head, a store read and a compare
// per node, capped at NODE_COUNT nodes. One word in flight. Reset clears the list,
// the counter and the output valid; ready right after.
module static_linked_list_engine #(
   parameter int NODE_COUNT = slle_pkg::NODE_COUNT_DEFAULT,
   parameter int IDX_W      = $clog2(NODE_COUNT),
   parameter int IN_W       = ((slle_pkg::MODE_W + IDX_W + slle_pkg::VALUE_W + 7) / 8) * 8,
   parameter int OUT_W      = ((IDX_W + slle_pkg::STATUS_W + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [IN_W-1:0]  req_tdata,   // mode, position, value, zero pad
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [OUT_W-1:0] rsp_tdata    // node_index, status, zero pad
);
   import slle_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   logic [IDX_W-1:0]    rsp_node_index;
   logic [STATUS_W-1:0] rsp_status;

   slle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   slle_dpath #(
      .NODE_COUNT (NODE_COUNT),
      .IDX_W      (IDX_W)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_mode       (req_tdata[MODE_W-1:0]),
      .req_position   (req_tdata[MODE_W +: IDX_W]),
      .req_value      (req_tdata[MODE_W + IDX_W +: VALUE_W]),
      .rsp_ready      (rsp_tready),
      .rsp_valid      (rsp_tvalid),
      .rsp_node_index (rsp_node_index),
      .rsp_status     (rsp_status)
   );

   // pack the result word
   assign rsp_tdata = OUT_W'({rsp_status, rsp_node_index});

endmodule
